[rtl/core/rqlh_pkg.sv]
// Shared types, constants and command codes of the run-queue latency histogram.
`timescale 1ns / 1ps
package rqlh_pkg;

    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_NUM_SLOTS   = 26;
    localparam int DEF_NUM_CPUS    = 8;

    localparam int TID_W    = 22;
    localparam int TIME_W   = 64;
    localparam int CPU_W    = 8;
    localparam int BIN_W    = 5;
    localparam int LAT_W    = 55;
    localparam int COUNT_W  = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 22;

    localparam int LOG2_CAP  = 25;
    localparam int NS_PER_US = 1000;

    // Division by 1000 is a shift by 3 followed by a reciprocal multiply for 125.
    // The 64 by 64 product is built from four 32 by 32 partial products.
    localparam int          DIV_STEPS   = 4;
    localparam int          DIV_PRE_SH  = 3;
    localparam int          DIV_POST_SH = 68;
    localparam logic [63:0] DIV_MAGIC   = 64'h20C4_9BA5_E353_F7CF;

    localparam logic [1:0] CMD_WAKE   = 2'd0;
    localparam logic [1:0] CMD_SWITCH = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TGID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PER_CPU_ENABLE = 2'd1;

    typedef struct packed {
        logic load_item;
        logic clr_step;
        logic scan_start;
        logic scan_key_b;
        logic enq_write;
        logic deq_inval;
        logic div_start;
        logic div_step;
        logic log_start;
        logic log_step;
        logic hist_rd;
        logic hist_wr;
        logic read_rd;
        logic read_cap;
        logic out_load;
    } rqlh_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic pass_a;
        logic pass_b;
        logic is_wake;
        logic is_switch;
        logic is_read;
        logic prev_run;
        logic scan_done;
        logic scan_hit;
        logic div_done;
        logic log_done;
    } rqlh_status_t;

endpackage

[rtl/core/rqlh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rqlh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/core/rqlh_datapath.sv]
// Datapath: item and configuration registers, table scan, divider, log2 and histograms.
`timescale 1ns / 1ps
module rqlh_datapath #(
    parameter int TABLE_DEPTH = rqlh_pkg::DEF_TABLE_DEPTH,
    parameter int NUM_SLOTS   = rqlh_pkg::DEF_NUM_SLOTS,
    parameter int NUM_CPUS    = rqlh_pkg::DEF_NUM_CPUS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rqlh_pkg::rqlh_cmd_t                 ctl,
    output rqlh_pkg::rqlh_status_t              sts,
    input  logic                                cfg_we,
    input  logic [rqlh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rqlh_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic [1:0]                          cmd,
    input  logic [rqlh_pkg::TIME_W-1:0]         now_ns,
    input  logic [rqlh_pkg::CPU_W-1:0]          cpu_id,
    input  logic [rqlh_pkg::TID_W-1:0]          task_a_tid,
    input  logic [rqlh_pkg::TID_W-1:0]          task_a_tgid,
    input  logic                                prev_still_running,
    input  logic [rqlh_pkg::TID_W-1:0]          task_b_tid,
    input  logic [rqlh_pkg::TID_W-1:0]          task_b_tgid,
    input  logic [rqlh_pkg::BIN_W-1:0]          read_bin,
    input  logic                                read_per_cpu,
    output logic                                latency_recorded,
    output logic [rqlh_pkg::BIN_W-1:0]          bucket,
    output logic [rqlh_pkg::LAT_W-1:0]          latency_us,
    output logic [rqlh_pkg::COUNT_W-1:0]        bin_count,
    output logic                                cpu_bin_updated
);
    import rqlh_pkg::*;

    localparam int TAW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TW     = 1 + TID_W + TIME_W;
    localparam int HN     = NUM_CPUS * NUM_SLOTS;
    localparam int HAW    = (HN > 1) ? $clog2(HN) : 1;
    localparam int SW     = $clog2(NUM_SLOTS);
    localparam int CLR_N  = (TABLE_DEPTH > HN) ? TABLE_DEPTH : HN;
    localparam int CLR_W  = (CLR_N > 1) ? $clog2(CLR_N) : 1;
    localparam int LG_W   = $clog2(LOG2_CAP + 1);
    localparam int DCNT_W = $clog2(DIV_STEPS);
    localparam int PROD_W = 2 * TIME_W;

    logic [TID_W-1:0]  tgid_filter_reg;
    logic              per_cpu_en_reg;

    logic [1:0]        cmd_reg;
    logic [TIME_W-1:0] now_reg;
    logic [CPU_W-1:0]  cpu_reg;
    logic [TID_W-1:0]  a_tid_reg;
    logic [TID_W-1:0]  a_tgid_reg;
    logic              prev_reg;
    logic [TID_W-1:0]  b_tid_reg;
    logic [TID_W-1:0]  b_tgid_reg;
    logic [BIN_W-1:0]  rbin_reg;
    logic              rpcpu_reg;

    logic [CLR_W-1:0]  clr_reg;

    logic              issue_active_reg;
    logic [TAW-1:0]    issue_idx_reg;
    logic              chk_valid_reg;
    logic [TAW-1:0]    chk_idx_reg;
    logic              chk_last_reg;
    logic [TID_W-1:0]  key_reg;
    logic              hit_reg;
    logic [TAW-1:0]    hit_idx_reg;
    logic [TIME_W-1:0] hit_time_reg;
    logic              free_found_reg;
    logic [TAW-1:0]    free_idx_reg;

    logic [TIME_W-1:0] dvd_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DCNT_W-1:0] div_cnt_reg;

    logic [LAT_W-1:0]  lg_val_reg;
    logic [LG_W-1:0]   lg_r_reg;

    logic [COUNT_W-1:0] ghist_reg [NUM_SLOTS];

    logic               res_rec_reg;
    logic [BIN_W-1:0]   res_bucket_reg;
    logic [LAT_W-1:0]   res_lat_reg;
    logic [COUNT_W-1:0] res_count_reg;
    logic               res_cpu_reg;

    logic               out_rec_reg;
    logic [BIN_W-1:0]   out_bucket_reg;
    logic [LAT_W-1:0]   out_lat_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_cpu_reg;

    logic              t_we;
    logic [TAW-1:0]    t_waddr;
    logic [TW-1:0]     t_wdata;
    logic [TW-1:0]     t_rdata;
    logic              c_we;
    logic [HAW-1:0]    c_waddr;
    logic [COUNT_W-1:0] c_wdata;
    logic [HAW-1:0]    c_raddr;
    logic [COUNT_W-1:0] c_rdata;

    logic              chk_match;
    logic              scan_done;
    logic              last_issue;
    logic [31:0]       pp_a;
    logic [31:0]       pp_b;
    logic [63:0]       pp;
    logic [1:0]        pp_pos;
    logic [PROD_W-1:0] pp_sh;
    logic [LAT_W-1:0]  quo;
    logic              log_done;
    logic [SW-1:0]     slot;
    logic              cpu_ok;
    logic              rbin_ok;
    logic [SW-1:0]     rbin_idx;
    logic [HAW-1:0]    hist_addr;
    logic [HAW-1:0]    read_addr;
    logic [COUNT_W-1:0] g_new;
    logic              cpu_upd;
    logic [COUNT_W-1:0] read_val;

    assign chk_match  = chk_valid_reg && t_rdata[TW-1] && (t_rdata[TW-2 -: TID_W] == key_reg);
    assign scan_done  = chk_valid_reg && (chk_match || chk_last_reg);
    assign last_issue = (issue_idx_reg == TAW'(TABLE_DEPTH - 1));
    assign pp_a       = div_cnt_reg[1] ? dvd_reg[63:32] : dvd_reg[31:0];
    assign pp_b       = div_cnt_reg[0] ? DIV_MAGIC[63:32] : DIV_MAGIC[31:0];
    assign pp         = 64'(pp_a) * 64'(pp_b);
    assign pp_pos     = {1'b0, div_cnt_reg[1]} + {1'b0, div_cnt_reg[0]};
    assign pp_sh      = {64'b0, pp} << {pp_pos, 5'b0};
    assign quo        = prod_reg[DIV_POST_SH +: LAT_W];
    assign log_done   = !((lg_val_reg > LAT_W'(1)) && (lg_r_reg < LG_W'(LOG2_CAP)));
    assign slot       = (int'(lg_r_reg) >= NUM_SLOTS) ? SW'(NUM_SLOTS - 1) : SW'(lg_r_reg);
    assign cpu_ok     = (int'(cpu_reg) < NUM_CPUS);
    assign rbin_ok    = (int'(rbin_reg) < NUM_SLOTS);
    assign rbin_idx   = SW'(rbin_reg);
    assign hist_addr  = HAW'(int'(cpu_reg) * NUM_SLOTS + int'(slot));
    assign read_addr  = HAW'(int'(cpu_reg) * NUM_SLOTS + int'(rbin_idx));
    assign g_new      = ghist_reg[slot] + COUNT_W'(1);
    assign cpu_upd    = per_cpu_en_reg && cpu_ok;

    always_comb
    begin
        read_val = '0;
        if (rbin_ok)
        begin
            if (!rpcpu_reg)
            begin
                read_val = ghist_reg[rbin_idx];
            end
            else if (cpu_ok)
            begin
                read_val = c_rdata;
            end
        end
    end

    assign sts.clr_done  = (clr_reg == CLR_W'(CLR_N - 1));
    assign sts.pass_a    = (tgid_filter_reg == '0) || (a_tgid_reg == tgid_filter_reg);
    assign sts.pass_b    = (tgid_filter_reg == '0) || (b_tgid_reg == tgid_filter_reg);
    assign sts.is_wake   = (cmd_reg == CMD_WAKE);
    assign sts.is_switch = (cmd_reg == CMD_SWITCH);
    assign sts.is_read   = (cmd_reg == CMD_READ);
    assign sts.prev_run  = prev_reg;
    assign sts.scan_done = scan_done;
    assign sts.scan_hit  = hit_reg || chk_match;
    assign sts.div_done  = (div_cnt_reg == DCNT_W'(DIV_STEPS - 1));
    assign sts.log_done  = log_done;

    always_comb
    begin
        t_we    = 1'b0;
        t_waddr = hit_idx_reg;
        t_wdata = {1'b0, b_tid_reg, now_reg};
        if (ctl.clr_step)
        begin
            t_we    = (int'(clr_reg) < TABLE_DEPTH);
            t_waddr = TAW'(clr_reg);
            t_wdata = '0;
        end
        else if (ctl.enq_write)
        begin
            t_we    = hit_reg || free_found_reg;
            t_waddr = hit_reg ? hit_idx_reg : free_idx_reg;
            t_wdata = {1'b1, a_tid_reg, now_reg};
        end
        else if (ctl.deq_inval)
        begin
            t_we = 1'b1;
        end
    end

    always_comb
    begin
        c_we    = 1'b0;
        c_waddr = hist_addr;
        c_wdata = c_rdata + COUNT_W'(1);
        c_raddr = ctl.read_rd ? read_addr : hist_addr;
        if (ctl.clr_step)
        begin
            c_we    = (int'(clr_reg) < HN);
            c_waddr = HAW'(clr_reg);
            c_wdata = '0;
        end
        else if (ctl.hist_wr)
        begin
            c_we = cpu_upd;
        end
    end

    rqlh_ram #(.WIDTH(TW), .DEPTH(TABLE_DEPTH), .AW(TAW)) u_table_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (issue_idx_reg),
        .rdata (t_rdata)
    );

    rqlh_ram #(.WIDTH(COUNT_W), .DEPTH(HN), .AW(HAW)) u_cpu_hist_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgid_filter_reg  <= '0;
            per_cpu_en_reg   <= 1'b0;
            clr_reg          <= '0;
            issue_active_reg <= 1'b0;
            chk_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                ghist_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TARGET_TGID:    tgid_filter_reg <= cfg_wdata;
                    REG_PER_CPU_ENABLE: per_cpu_en_reg  <= cfg_wdata[0];
                    default:            ;
                endcase
            end
            if (ctl.clr_step)
            begin
                clr_reg <= clr_reg + CLR_W'(1);
            end
            if (ctl.scan_start)
            begin
                issue_active_reg <= 1'b1;
                chk_valid_reg    <= 1'b0;
            end
            else
            begin
                chk_valid_reg <= issue_active_reg && !scan_done;
                if (scan_done || (issue_active_reg && last_issue))
                begin
                    issue_active_reg <= 1'b0;
                end
            end
            if (ctl.hist_wr)
            begin
                ghist_reg[slot] <= g_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            cmd_reg        <= cmd;
            now_reg        <= now_ns;
            cpu_reg        <= cpu_id;
            a_tid_reg      <= task_a_tid;
            a_tgid_reg     <= task_a_tgid;
            prev_reg       <= prev_still_running;
            b_tid_reg      <= task_b_tid;
            b_tgid_reg     <= task_b_tgid;
            rbin_reg       <= read_bin;
            rpcpu_reg      <= read_per_cpu;
            res_rec_reg    <= 1'b0;
            res_bucket_reg <= '0;
            res_lat_reg    <= '0;
            res_count_reg  <= '0;
            res_cpu_reg    <= 1'b0;
        end

        if (ctl.scan_start)
        begin
            issue_idx_reg  <= '0;
            key_reg        <= ctl.scan_key_b ? b_tid_reg : a_tid_reg;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (issue_active_reg)
            begin
                issue_idx_reg <= issue_idx_reg + TAW'(1);
                chk_idx_reg   <= issue_idx_reg;
                chk_last_reg  <= last_issue;
            end
            if (chk_match)
            begin
                hit_reg      <= 1'b1;
                hit_idx_reg  <= chk_idx_reg;
                hit_time_reg <= t_rdata[TIME_W-1:0];
            end
            else if (chk_valid_reg && !t_rdata[TW-1] && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= chk_idx_reg;
            end
        end

        if (ctl.div_start)
        begin
            dvd_reg     <= (now_reg - hit_time_reg) >> DIV_PRE_SH;
            prod_reg    <= '0;
            div_cnt_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            prod_reg    <= prod_reg + pp_sh;
            div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
        end

        if (ctl.log_start)
        begin
            lg_val_reg <= quo;
            lg_r_reg   <= '0;
        end
        else if (ctl.log_step && !log_done)
        begin
            lg_val_reg <= lg_val_reg >> 1;
            lg_r_reg   <= lg_r_reg + LG_W'(1);
        end

        if (ctl.hist_wr)
        begin
            res_rec_reg    <= 1'b1;
            res_bucket_reg <= BIN_W'(slot);
            res_lat_reg    <= quo;
            res_count_reg  <= g_new;
            res_cpu_reg    <= cpu_upd;
        end
        if (ctl.read_cap)
        begin
            res_count_reg <= read_val;
        end

        if (ctl.out_load)
        begin
            out_rec_reg    <= res_rec_reg;
            out_bucket_reg <= res_bucket_reg;
            out_lat_reg    <= res_lat_reg;
            out_count_reg  <= res_count_reg;
            out_cpu_reg    <= res_cpu_reg;
        end
    end

    assign latency_recorded = out_rec_reg;
    assign bucket           = out_bucket_reg;
    assign latency_us       = out_lat_reg;
    assign bin_count        = out_count_reg;
    assign cpu_bin_updated  = out_cpu_reg;
endmodule

[rtl/core/rqlh_ctrl.sv]
// State machine that sequences clearing, table scans, division, log2, updates, reads.
`timescale 1ns / 1ps
module rqlh_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  rqlh_pkg::rqlh_status_t sts,
    output rqlh_pkg::rqlh_cmd_t    ctl
);
    import rqlh_pkg::*;

    typedef enum logic [16:0] {
        S_CLEAR    = 17'b00000000000000001,
        S_IDLE     = 17'b00000000000000010,
        S_DECODE   = 17'b00000000000000100,
        S_ENQ_GO   = 17'b00000000000001000,
        S_ENQ_SCAN = 17'b00000000000010000,
        S_ENQ_WR   = 17'b00000000000100000,
        S_DEQ_GO   = 17'b00000000001000000,
        S_DEQ_SCAN = 17'b00000000010000000,
        S_DEQ_HIT  = 17'b00000000100000000,
        S_DIV      = 17'b00000001000000000,
        S_LOG_GO   = 17'b00000010000000000,
        S_LOG      = 17'b00000100000000000,
        S_HIST_RD  = 17'b00001000000000000,
        S_HIST_WR  = 17'b00010000000000000,
        S_READ_RD  = 17'b00100000000000000,
        S_READ_CAP = 17'b01000000000000000,
        S_DONE     = 17'b10000000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.is_wake)
                begin
                    state_next = sts.pass_a ? S_ENQ_GO : S_DONE;
                end
                else if (sts.is_switch)
                begin
                    if (sts.prev_run && sts.pass_a)
                    begin
                        state_next = S_ENQ_GO;
                    end
                    else
                    begin
                        state_next = sts.pass_b ? S_DEQ_GO : S_DONE;
                    end
                end
                else if (sts.is_read)
                begin
                    state_next = S_READ_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_ENQ_GO:
            begin
                ctl.scan_start = 1'b1;
                state_next     = S_ENQ_SCAN;
            end
            S_ENQ_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_ENQ_WR;
                end
            end
            S_ENQ_WR:
            begin
                ctl.enq_write = 1'b1;
                state_next    = (sts.is_switch && sts.pass_b) ? S_DEQ_GO : S_DONE;
            end
            S_DEQ_GO:
            begin
                ctl.scan_start = 1'b1;
                ctl.scan_key_b = 1'b1;
                state_next     = S_DEQ_SCAN;
            end
            S_DEQ_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = sts.scan_hit ? S_DEQ_HIT : S_DONE;
                end
            end
            S_DEQ_HIT:
            begin
                ctl.deq_inval = 1'b1;
                ctl.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_LOG_GO;
                end
            end
            S_LOG_GO:
            begin
                ctl.log_start = 1'b1;
                state_next    = S_LOG;
            end
            S_LOG:
            begin
                ctl.log_step = 1'b1;
                if (sts.log_done)
                begin
                    state_next = S_HIST_RD;
                end
            end
            S_HIST_RD:
            begin
                ctl.hist_rd = 1'b1;
                state_next  = S_HIST_WR;
            end
            S_HIST_WR:
            begin
                ctl.hist_wr = 1'b1;
                state_next  = S_DONE;
            end
            S_READ_RD:
            begin
                ctl.read_rd = 1'b1;
                state_next  = S_READ_CAP;
            end
            S_READ_CAP:
            begin
                ctl.read_cap = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

[rtl/core/run_queue_latency_histogram.sv]
// Top level of the run-queue latency histogram.
// Scheduler events arrive on the in channel (valid/ready), one beat per event:
// cmd selects a wakeup, a context switch or a histogram read. Each event gives
// exactly one result beat on the out channel (valid/ready).
// Registers (filter process id, per-cpu enable) are written through cfg_we,
// cfg_index and cfg_wdata; the user must write them only while the block is
// idle, as the block itself does not enforce this. A wakeup that passes the
// filter scans the task table once; a switch scans it at most twice and, when
// the switched-in task is found, runs a reciprocal divide by 1000 and log2
// steps up to the LOG2_CAP limit. Events are handled one at a time; the table
// scan over the one-read table memory sets the rate, and in_ready returns in
// the cycle after the result loads. After reset the table and the per-cpu
// histogram memory are swept to zero over max(TABLE_DEPTH, NUM_CPUS * NUM_SLOTS)
// addresses, during which in_ready is low.
// A finished result waits in the output register while the receiver stalls; the
// next event is accepted meanwhile and holds its result until that beat is taken.
`timescale 1ns / 1ps
module run_queue_latency_histogram #(
    parameter int TABLE_DEPTH = rqlh_pkg::DEF_TABLE_DEPTH,
    parameter int NUM_SLOTS   = rqlh_pkg::DEF_NUM_SLOTS,
    parameter int NUM_CPUS    = rqlh_pkg::DEF_NUM_CPUS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rqlh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rqlh_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      cmd,
    input  logic [rqlh_pkg::TIME_W-1:0]     now_ns,
    input  logic [rqlh_pkg::CPU_W-1:0]      cpu_id,
    input  logic [rqlh_pkg::TID_W-1:0]      task_a_tid,
    input  logic [rqlh_pkg::TID_W-1:0]      task_a_tgid,
    input  logic                            prev_still_running,
    input  logic [rqlh_pkg::TID_W-1:0]      task_b_tid,
    input  logic [rqlh_pkg::TID_W-1:0]      task_b_tgid,
    input  logic [rqlh_pkg::BIN_W-1:0]      read_bin,
    input  logic                            read_per_cpu,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            latency_recorded,
    output logic [rqlh_pkg::BIN_W-1:0]      bucket,
    output logic [rqlh_pkg::LAT_W-1:0]      latency_us,
    output logic [rqlh_pkg::COUNT_W-1:0]    bin_count,
    output logic                            cpu_bin_updated
);
    import rqlh_pkg::*;

    rqlh_cmd_t    ctl;
    rqlh_status_t sts;

    rqlh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    rqlh_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NUM_SLOTS   (NUM_SLOTS),
        .NUM_CPUS    (NUM_CPUS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctl                (ctl),
        .sts                (sts),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .cmd                (cmd),
        .now_ns             (now_ns),
        .cpu_id             (cpu_id),
        .task_a_tid         (task_a_tid),
        .task_a_tgid        (task_a_tgid),
        .prev_still_running (prev_still_running),
        .task_b_tid         (task_b_tid),
        .task_b_tgid        (task_b_tgid),
        .read_bin           (read_bin),
        .read_per_cpu       (read_per_cpu),
        .latency_recorded   (latency_recorded),
        .bucket             (bucket),
        .latency_us         (latency_us),
        .bin_count          (bin_count),
        .cpu_bin_updated    (cpu_bin_updated)
    );
endmodule

[dv/testbench.sv]
// Self-checking testbench for the run-queue latency histogram with a scoreboard class.
`timescale 1ns / 1ps
module testbench;
    import rqlh_pkg::*;

    localparam int DEPTH = DEF_TABLE_DEPTH;
    localparam int SLOTS = DEF_NUM_SLOTS;
    localparam int CPUS  = DEF_NUM_CPUS;

    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [TIME_W-1:0] now;
        logic [CPU_W-1:0]  cpu;
        logic [TID_W-1:0]  a_tid;
        logic [TID_W-1:0]  a_tgid;
        logic              prev_run;
        logic [TID_W-1:0]  b_tid;
        logic [TID_W-1:0]  b_tgid;
        logic [BIN_W-1:0]  rbin;
        logic              rpcpu;
    } sched_event_t;

    localparam int EV_W = $bits(sched_event_t);

    typedef struct packed {
        logic               recorded;
        logic [BIN_W-1:0]   bucket;
        logic [LAT_W-1:0]   lat_us;
        logic [COUNT_W-1:0] count;
        logic               cpu_upd;
    } hist_result_t;

    class latency_scoreboard;
        logic [TID_W-1:0]   filter_tgid;
        logic               cpu_enable;
        logic               slot_used [DEPTH];
        logic [TID_W-1:0]   slot_tid [DEPTH];
        logic [TIME_W-1:0]  slot_time [DEPTH];
        logic [COUNT_W-1:0] global_hist [SLOTS];
        logic [COUNT_W-1:0] cpu_hist [CPUS*SLOTS];
        hist_result_t       pending_results[$];
        int                 mismatches;
        int                 recorded_seen;

        function new();
            filter_tgid = '0;
            cpu_enable  = 1'b0;
            mismatches  = 0;
            recorded_seen = 0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            foreach (global_hist[i]) global_hist[i] = '0;
            foreach (cpu_hist[i]) cpu_hist[i] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_TARGET_TGID) filter_tgid = val;
            else if (idx == REG_PER_CPU_ENABLE) cpu_enable = val[0];
        endfunction

        function bit tgid_ok(logic [TID_W-1:0] tgid);
            return filter_tgid == '0 || tgid == filter_tgid;
        endfunction

        function void store_wait(logic [TID_W-1:0] tgid, logic [TID_W-1:0] tid,
                                 logic [TIME_W-1:0] now);
            int free_slot;
            free_slot = -1;
            if (!tgid_ok(tgid)) return;
            for (int i = 0; i < DEPTH; i++) begin
                if (slot_used[i]) begin
                    if (slot_tid[i] == tid) begin
                        slot_time[i] = now;
                        return;
                    end
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (free_slot >= 0) begin
                slot_used[free_slot] = 1'b1;
                slot_tid[free_slot]  = tid;
                slot_time[free_slot] = now;
            end
        endfunction

        function void note_event(sched_event_t ev);
            hist_result_t r;
            int hit;
            logic [TIME_W-1:0] us;
            int b;
            r = '0;
            hit = -1;
            if (ev.cmd == CMD_WAKE) begin
                store_wait(ev.a_tgid, ev.a_tid, ev.now);
            end else if (ev.cmd == CMD_SWITCH) begin
                if (ev.prev_run) store_wait(ev.a_tgid, ev.a_tid, ev.now);
                if (tgid_ok(ev.b_tgid)) begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (hit < 0 && slot_used[i] && slot_tid[i] == ev.b_tid) hit = i;
                    end
                end
                if (hit >= 0) begin
                    us = (ev.now - slot_time[hit]) / TIME_W'(NS_PER_US);
                    slot_used[hit] = 1'b0;
                    b = 0;
                    while (us >> b > 1 && b < LOG2_CAP) b++;
                    if (b >= SLOTS) b = SLOTS - 1;
                    global_hist[b] += 1;
                    r.recorded = 1'b1;
                    r.bucket = BIN_W'(b);
                    r.lat_us = us[LAT_W-1:0];
                    r.count = global_hist[b];
                    if (cpu_enable && ev.cpu < CPUS) begin
                        cpu_hist[ev.cpu*SLOTS + b] += 1;
                        r.cpu_upd = 1'b1;
                    end
                end
            end else if (ev.cmd == CMD_READ) begin
                if (ev.rbin < SLOTS) begin
                    if (!ev.rpcpu) r.count = global_hist[ev.rbin];
                    else if (ev.cpu < CPUS) r.count = cpu_hist[ev.cpu*SLOTS + ev.rbin];
                end
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(hist_result_t got);
            hist_result_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result beat: %p", got);
                return;
            end
            want = pending_results.pop_front();
            if (got.recorded) recorded_seen++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    sched_event_t ev_drv = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    hist_result_t res_mon;
    logic quiet_tail = 1'b0;
    int accepted = 0;
    latency_scoreboard sb = new();

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    run_queue_latency_histogram dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(ev_drv.cmd), .now_ns(ev_drv.now), .cpu_id(ev_drv.cpu),
        .task_a_tid(ev_drv.a_tid), .task_a_tgid(ev_drv.a_tgid),
        .prev_still_running(ev_drv.prev_run),
        .task_b_tid(ev_drv.b_tid), .task_b_tgid(ev_drv.b_tgid),
        .read_bin(ev_drv.rbin), .read_per_cpu(ev_drv.rpcpu),
        .out_valid(out_valid), .out_ready(out_ready),
        .latency_recorded(res_mon.recorded), .bucket(res_mon.bucket),
        .latency_us(res_mon.lat_us), .bin_count(res_mon.count),
        .cpu_bin_updated(res_mon.cpu_upd)
    );

    // The receiver stalls in random bursts until the quiet tail of the run.
    always @(posedge clk)
    begin
        if (out_valid && out_ready) sb.check_result(res_mon);
    end

    initial
    begin
        int stall;
        stall = 0;
        forever begin
            @(posedge clk);
            if (stall > 0) begin
                stall--;
                out_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Valid stays high from one beat to the next unless an idle burst is drawn.
    task automatic send_event(sched_event_t ev);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        ev_drv <= ev;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_event(ev);
        accepted++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    function automatic sched_event_t random_event(logic [TIME_W-1:0] t, int tid_span,
                                                  logic [TID_W-1:0] tg);
        sched_event_t ev;
        ev = EV_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        ev.cmd = $urandom_range(0, 9) < 4 ? CMD_WAKE
               : ($urandom_range(0, 9) < 8 ? CMD_SWITCH : CMD_READ);
        if ($urandom_range(0, 30) == 0) ev.cmd = CMD_SPARE;
        ev.now = t;
        if ($urandom_range(0, 9) != 0) begin
            ev.a_tid = TID_W'($urandom_range(0, tid_span));
            ev.b_tid = TID_W'($urandom_range(0, tid_span));
            ev.cpu = CPU_W'($urandom_range(0, 9));
            ev.rbin = BIN_W'($urandom_range(0, 27));
        end
        if ($urandom_range(0, 4) != 0) begin
            ev.a_tgid = tg;
            ev.b_tgid = tg;
        end
        return ev;
    endfunction

    initial
    begin
        sched_event_t ev;
        logic [TIME_W-1:0] t;
        logic [TID_W-1:0] tg;
        int span;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed events: wraps, overwrite, missing key, reads at the edges.
        write_reg(REG_PER_CPU_ENABLE, CFG_W'(1));
        ev = '0;
        ev.cmd = CMD_WAKE; ev.now = '1; ev.a_tid = '1; ev.a_tgid = '1;
        send_event(ev);
        ev.cmd = CMD_SWITCH; ev.now = 64'd5000; ev.b_tid = '1; ev.cpu = 8'd7;
        send_event(ev);
        ev.cmd = CMD_WAKE; ev.a_tid = 22'd3; ev.now = 64'd10; send_event(ev);
        ev.now = 64'd100; send_event(ev);
        ev.cmd = CMD_SWITCH; ev.b_tid = 22'd3; ev.now = 64'd999; ev.cpu = '1;
        send_event(ev);
        ev.b_tid = 22'd3; send_event(ev);
        ev.cmd = CMD_WAKE; ev.a_tid = 22'd4; ev.now = 64'd0; send_event(ev);
        ev.cmd = CMD_SWITCH; ev.prev_run = 1'b1; ev.a_tid = 22'd5; ev.b_tid = 22'd4;
        ev.now = '1; ev.cpu = 8'd0; send_event(ev);
        ev.prev_run = 1'b0; ev.b_tid = 22'd5; ev.now = 64'd40_000_000; send_event(ev);
        ev.cmd = CMD_READ;
        for (int i = 0; i < 6; i++) begin
            ev.rbin = (i < 3) ? 5'd25 : (i == 3 ? 5'd0 : 5'h1F);
            ev.rpcpu = i[0];
            ev.cpu = (i == 5) ? 8'hFF : 8'd0;
            send_event(ev);
        end
        ev = '1; send_event(ev);
        drain();

        // Table overflow: fill past capacity, then drain some entries.
        write_reg(REG_TARGET_TGID, '0);
        for (int i = 0; i < DEPTH + 4; i++) begin
            ev = '0; ev.cmd = CMD_WAKE; ev.a_tid = TID_W'(i + 100);
            ev.now = TIME_W'(i * 3000);
            send_event(ev);
        end
        for (int i = 0; i < 8; i++) begin
            ev = '0; ev.cmd = CMD_SWITCH; ev.b_tid = TID_W'(DEPTH + 102 - i);
            ev.now = 64'd2_000_000; send_event(ev);
        end
        drain();

        t = 64'd0;
        for (int phase = 0; phase < 4; phase++) begin
            tg = (phase == 1) ? '1 : (phase == 2 ? 22'd7 : '0);
            write_reg(REG_TARGET_TGID, tg);
            write_reg(REG_PER_CPU_ENABLE, CFG_W'(phase != 2));
            if (phase == 3) t = 64'hFFFF_FFFF_FF00_0000;
            span = (phase == 0) ? 40 : 12;
            for (int n = 0; n < 170; n++) begin
                t += (n % 4 == 0) ? {$urandom, $urandom} >> $urandom_range(20, 63)
                                  : TIME_W'($urandom_range(0, 2_000_000));
                send_event(random_event(t, span, tg));
            end
            drain();
        end
        // Quiet tail without idling on either side.
        quiet_tail <= 1'b1;
        for (int n = 0; n < 150; n++) begin
            t += TIME_W'($urandom_range(0, 5_000_000));
            send_event(random_event(t, 12, '0));
        end
        drain();
        read_all();
    end

    task automatic read_all();
        sched_event_t ev;
        ev = '0;
        ev.cmd = CMD_READ;
        for (int b = 0; b < SLOTS; b++) begin
            ev.rbin = BIN_W'(b); ev.rpcpu = 1'b0; send_event(ev);
            ev.rpcpu = 1'b1; ev.cpu = CPU_W'(b % CPUS); send_event(ev);
        end
        drain();
        $display("Covered %0d events, %0d recorded waits, filter and per-cpu settings swept.",
                 accepted, sb.recorded_seen);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    endtask

    initial
    begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[run_queue_latency_histogram.f]
rtl/core/rqlh_pkg.sv
rtl/core/rqlh_ram.sv
rtl/core/rqlh_datapath.sv
rtl/core/rqlh_ctrl.sv
rtl/core/run_queue_latency_histogram.sv
dv/testbench.sv
